[hdl/assert_macros.svh]
// Assertion macros for the checker module of the connection table.
// Depends on nothing; every macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// A condition that must hold in the cycle after the trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/tsct_pkg.sv]
// Package of the transport server connection table: word types and codes.
// Depends on nothing.
package tsct_pkg;

    localparam logic [2:0] CMD_OPEN   = 3'd0;
    localparam logic [2:0] CMD_LISTEN = 3'd1;
    localparam logic [2:0] CMD_READ   = 3'd2;
    localparam logic [2:0] CMD_CLOSE  = 3'd3;
    localparam logic [2:0] CMD_SEG    = 3'd4;

    localparam logic [2:0] SEG_SYN     = 3'd0;
    localparam logic [2:0] SEG_SYNACK  = 3'd1;
    localparam logic [2:0] SEG_FIN     = 3'd2;
    localparam logic [2:0] SEG_FINACK  = 3'd3;
    localparam logic [2:0] SEG_DATA    = 3'd4;
    localparam logic [2:0] SEG_DATAACK = 3'd5;

    localparam logic [1:0] ST_CLOSED = 2'd0;
    localparam logic [1:0] ST_LISTEN = 2'd1;
    localparam logic [1:0] ST_CONN   = 2'd2;
    localparam logic [1:0] ST_CWAIT  = 2'd3;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_REPLY  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_SHORT = 2'd2;
    localparam logic [1:0] STAT_BAD   = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [2:0]  socket_id;
        logic [15:0] local_port;
        logic [6:0]  read_length;
        logic [2:0]  seg_type;
        logic [15:0] seg_src_port;
        logic [15:0] seg_dest_port;
        logic [31:0] seg_seq;
        logic [10:0] seg_length;
        logic [7:0]  payload_byte;
        logic        is_payload;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [1:0]  status;
        logic [2:0]  out_socket_id;
        logic [1:0]  conn_state;
        logic [2:0]  reply_type;
        logic [15:0] reply_src_port;
        logic [15:0] reply_dest_port;
        logic [31:0] reply_ack;
        logic [7:0]  read_byte;
        logic        last;
    } out_word_t;

endpackage

[hdl/tsct_if.sv]
// Valid/ready channel interfaces for the input and result words.
// Depends on tsct_pkg.
interface tsct_in_if;
    logic               valid;
    logic               ready;
    tsct_pkg::in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tsct_out_if;
    logic                valid;
    logic                ready;
    tsct_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/transport_server_connection_table_top.sv]
// Top level of the transport server connection table.
// Depends on tsct_pkg, tsct_if, tsct_ram and tsct_match.
//
// The block takes words on req (commands, segment headers and payload bytes)
// and gives result words on rsp; both are valid/ready channels and a word
// moves when valid and ready are high at a rising edge of clk.
// Every input word gives at least one result word and the final one of each
// input carries last. A read gives one word per delivered byte.
// An input word passes S_IDLE and S_LOOK: in the accept cycle the entry table
// is read, and in S_LOOK the block decides, writes back and loads the output
// register, waiting there while the output register is still held. A new word
// is taken only once the block is back in S_IDLE. For each byte, a read passes
// S_RADDR to address the receive buffer and S_RDATA to take its data.
// Entry state sits in a small table RAM; the port match and the free-entry
// search use the used flags and server ports kept in flip-flops.
// Received bytes sit in one buffer RAM of NUM_CONNECTIONS * BUFFER_BYTES bytes.
// Reset clears the used flags and the payload tracking at once; there is no
// clearing pass, and the block is ready right after reset.
// When the receiver stalls, the result stays in the output register and the
// block waits before loading the next one.
module transport_server_connection_table_top #(
    parameter int NUM_CONNECTIONS = 8,
    parameter int BUFFER_BYTES    = 1024,
    parameter int MAX_PAYLOAD     = 1024,
    parameter int MAX_READ        = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    tsct_in_if.sink    req,
    tsct_out_if.source rsp
);
    localparam int IW = (NUM_CONNECTIONS > 1) ? $clog2(NUM_CONNECTIONS) : 1;
    localparam int FW = $clog2(BUFFER_BYTES + 1);
    localparam int PW = $clog2(BUFFER_BYTES);
    localparam int AW = (NUM_CONNECTIONS * BUFFER_BYTES > 1) ?
                        $clog2(NUM_CONNECTIONS * BUFFER_BYTES) : 1;
    localparam int CW = FW + 12;

    typedef struct packed {
        logic [1:0]    st;
        logic [15:0]   client;
        logic [31:0]   seq;
        logic [FW-1:0] fill;
        logic [PW-1:0] rptr;
    } ent_t;

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_RADDR, S_RDATA} state_t;

    state_t              state_reg, state_next;
    tsct_pkg::in_word_t  in_reg, in_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic                found_reg, found_next;
    logic [NUM_CONNECTIONS-1:0] used_reg, used_next;
    logic [15:0]         port_reg [NUM_CONNECTIONS];
    logic [15:0]         port_next [NUM_CONNECTIONS];
    logic [IW-1:0]       pe_reg, pe_next;
    logic [10:0]         pl_reg, pl_next;
    logic                pk_reg, pk_next;
    ent_t                ent_reg, ent_next;
    logic [6:0]          cnt_reg, cnt_next;
    logic                ov_reg, ov_next;
    tsct_pkg::out_word_t out_reg, out_next;

    logic                match_found, free_found;
    logic [IW-1:0]       match_idx, free_idx;
    logic [IW-1:0]       idx_sel;
    logic                sel_found;

    logic                tab_we, tab_re;
    ent_t                tab_wdata, tab_rdata;
    logic [IW-1:0]       tab_raddr;
    logic                buf_we, buf_re;
    logic [AW-1:0]       buf_waddr, buf_raddr;
    logic [7:0]          buf_rdata;
    logic                out_free;

    tsct_match #(.NUM_CONNECTIONS(NUM_CONNECTIONS)) u_match (
        .used        (used_reg),
        .ports       (port_reg),
        .key_port    (req.data.seg_dest_port),
        .match_found (match_found),
        .match_idx   (match_idx),
        .free_found  (free_found),
        .free_idx    (free_idx)
    );

    tsct_ram #(.WIDTH($bits(ent_t)), .DEPTH(NUM_CONNECTIONS)) u_tab_ram (
        .clk   (clk),
        .we    (tab_we),
        .waddr (idx_reg),
        .wdata (tab_wdata),
        .re    (tab_re),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    tsct_ram #(.WIDTH(8), .DEPTH(NUM_CONNECTIONS * BUFFER_BYTES)) u_buf_ram (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (in_reg.payload_byte),
        .re    (buf_re),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = ov_reg;
    assign rsp.data  = out_reg;
    assign out_free  = !ov_reg || rsp.ready;

    always_comb
    begin
        idx_sel   = IW'(req.data.socket_id);
        sel_found = 1'b1;
        if (req.data.is_payload)
        begin
            idx_sel = pe_reg;
        end
        else if (req.data.command == tsct_pkg::CMD_OPEN)
        begin
            idx_sel   = free_idx;
            sel_found = free_found;
        end
        else if (req.data.command == tsct_pkg::CMD_SEG)
        begin
            idx_sel   = match_idx;
            sel_found = match_found;
        end
    end

    always_comb
    begin
        logic [FW:0]       ring_sum;
        logic [AW-1:0]     base;
        logic [6:0]        rl;
        logic              id_ok;
        logic              load;
        logic              fits;
        ent_t              ent;
        tsct_pkg::out_word_t res;

        state_next = state_reg;
        in_next    = in_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        used_next  = used_reg;
        port_next  = port_reg;
        pe_next    = pe_reg;
        pl_next    = pl_reg;
        pk_next    = pk_reg;
        ent_next   = ent_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && !rsp.ready;
        out_next   = out_reg;

        tab_re     = 1'b0;
        tab_raddr  = idx_sel;
        tab_we     = 1'b0;
        buf_we     = 1'b0;
        buf_re     = 1'b0;
        load       = 1'b0;

        ent      = tab_rdata;
        base     = AW'(idx_reg) * AW'(BUFFER_BYTES);
        ring_sum = (FW + 1)'(tab_rdata.rptr) + (FW + 1)'(tab_rdata.fill);
        if (ring_sum >= (FW + 1)'(BUFFER_BYTES))
        begin
            ring_sum = ring_sum - (FW + 1)'(BUFFER_BYTES);
        end
        buf_waddr = base + AW'(ring_sum[PW-1:0]);
        buf_raddr = base + AW'(ent_reg.rptr);
        rl = (in_reg.read_length > 7'(MAX_READ)) ? 7'(MAX_READ) : in_reg.read_length;
        id_ok = (7'(in_reg.socket_id) < 7'(NUM_CONNECTIONS)) && used_reg[idx_reg];
        fits = (17'(in_reg.seg_length) <= 17'(MAX_PAYLOAD)) &&
               (CW'(tab_rdata.fill) + CW'(in_reg.seg_length) <= CW'(BUFFER_BYTES));

        res = '0;
        res.result_kind = tsct_pkg::KIND_NONE;
        res.last = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    in_next    = req.data;
                    idx_next   = idx_sel;
                    found_next = sel_found;
                    tab_re     = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                    if (in_reg.is_payload)
                    begin
                        if (pl_reg != '0)
                        begin
                            pl_next = pl_reg - 11'd1;
                            if (pk_reg && tab_rdata.fill < FW'(BUFFER_BYTES))
                            begin
                                buf_we   = 1'b1;
                                ent.fill = tab_rdata.fill + FW'(1);
                                tab_we   = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        case (in_reg.command)
                            tsct_pkg::CMD_OPEN:
                            begin
                                res.result_kind = tsct_pkg::KIND_STATUS;
                                if (found_reg)
                                begin
                                    used_next[idx_reg] = 1'b1;
                                    port_next[idx_reg] = in_reg.local_port;
                                    ent    = '0;
                                    ent.st = tsct_pkg::ST_CLOSED;
                                    tab_we = 1'b1;
                                    res.out_socket_id = 3'(idx_reg);
                                end
                                else
                                begin
                                    res.status = tsct_pkg::STAT_FULL;
                                end
                            end
                            tsct_pkg::CMD_LISTEN:
                            begin
                                res.result_kind   = tsct_pkg::KIND_STATUS;
                                res.out_socket_id = in_reg.socket_id;
                                if (id_ok)
                                begin
                                    ent.st         = tsct_pkg::ST_LISTEN;
                                    tab_we         = 1'b1;
                                    res.conn_state = tsct_pkg::ST_LISTEN;
                                end
                                else
                                begin
                                    res.status = tsct_pkg::STAT_BAD;
                                end
                            end
                            tsct_pkg::CMD_READ:
                            begin
                                res.result_kind   = tsct_pkg::KIND_STATUS;
                                res.out_socket_id = in_reg.socket_id;
                                if (!id_ok)
                                begin
                                    res.status = tsct_pkg::STAT_BAD;
                                end
                                else if (CW'(tab_rdata.fill) < CW'(rl))
                                begin
                                    res.status     = tsct_pkg::STAT_SHORT;
                                    res.conn_state = tab_rdata.st;
                                end
                                else if (rl == '0)
                                begin
                                    res.conn_state = tab_rdata.st;
                                end
                                else
                                begin
                                    load       = 1'b0;
                                    ent_next   = tab_rdata;
                                    cnt_next   = rl;
                                    state_next = S_RADDR;
                                end
                            end
                            tsct_pkg::CMD_CLOSE:
                            begin
                                res.result_kind   = tsct_pkg::KIND_STATUS;
                                res.out_socket_id = in_reg.socket_id;
                                if (id_ok)
                                begin
                                    used_next[idx_reg] = 1'b0;
                                    ent.st   = tsct_pkg::ST_CLOSED;
                                    ent.fill = '0;
                                    ent.rptr = '0;
                                    tab_we   = 1'b1;
                                    if (pe_reg == idx_reg)
                                    begin
                                        pk_next = 1'b0;
                                    end
                                end
                                else
                                begin
                                    res.status = tsct_pkg::STAT_BAD;
                                end
                            end
                            tsct_pkg::CMD_SEG:
                            begin
                                pl_next = in_reg.seg_length;
                                pk_next = 1'b0;
                                pe_next = idx_reg;
                                if (found_reg)
                                begin
                                    res.result_kind     = tsct_pkg::KIND_REPLY;
                                    res.out_socket_id   = 3'(idx_reg);
                                    res.reply_src_port  = in_reg.seg_dest_port;
                                    res.reply_dest_port = in_reg.seg_src_port;
                                    case (tab_rdata.st)
                                        tsct_pkg::ST_LISTEN:
                                        begin
                                            if (in_reg.seg_type == tsct_pkg::SEG_SYN)
                                            begin
                                                ent.st     = tsct_pkg::ST_CONN;
                                                ent.client = in_reg.seg_src_port;
                                                ent.seq    = in_reg.seg_seq;
                                                tab_we     = 1'b1;
                                                res.reply_type = tsct_pkg::SEG_SYNACK;
                                            end
                                            else
                                            begin
                                                res = '0;
                                                res.result_kind = tsct_pkg::KIND_NONE;
                                                res.last = 1'b1;
                                            end
                                        end
                                        tsct_pkg::ST_CONN:
                                        begin
                                            if (in_reg.seg_type == tsct_pkg::SEG_FIN)
                                            begin
                                                ent.st = tsct_pkg::ST_CWAIT;
                                                tab_we = 1'b1;
                                                res.reply_type = tsct_pkg::SEG_FINACK;
                                            end
                                            else if (in_reg.seg_type == tsct_pkg::SEG_SYN)
                                            begin
                                                res.reply_type = tsct_pkg::SEG_SYNACK;
                                            end
                                            else if (in_reg.seg_type == tsct_pkg::SEG_DATA &&
                                                     tab_rdata.seq != in_reg.seg_seq)
                                            begin
                                                res.reply_type = tsct_pkg::SEG_DATAACK;
                                                res.reply_ack  = tab_rdata.seq;
                                            end
                                            else if (in_reg.seg_type == tsct_pkg::SEG_DATA &&
                                                     fits)
                                            begin
                                                pk_next = 1'b1;
                                                ent.seq = in_reg.seg_seq +
                                                          32'(in_reg.seg_length);
                                                tab_we  = 1'b1;
                                                res.reply_type = tsct_pkg::SEG_DATAACK;
                                                res.reply_ack  = ent.seq;
                                            end
                                            else
                                            begin
                                                res = '0;
                                                res.result_kind = tsct_pkg::KIND_NONE;
                                                res.last = 1'b1;
                                            end
                                        end
                                        tsct_pkg::ST_CWAIT:
                                        begin
                                            if (in_reg.seg_type == tsct_pkg::SEG_FIN)
                                            begin
                                                res.reply_type = tsct_pkg::SEG_FINACK;
                                            end
                                            else
                                            begin
                                                res = '0;
                                                res.result_kind = tsct_pkg::KIND_NONE;
                                                res.last = 1'b1;
                                            end
                                        end
                                        default:
                                        begin
                                            res = '0;
                                            res.result_kind = tsct_pkg::KIND_NONE;
                                            res.last = 1'b1;
                                        end
                                    endcase
                                    if (res.result_kind == tsct_pkg::KIND_REPLY)
                                    begin
                                        res.conn_state = ent.st;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            S_RADDR:
            begin
                buf_re = 1'b1;
                if (ent_reg.rptr == PW'(BUFFER_BYTES - 1))
                begin
                    ent_next.rptr = '0;
                end
                else
                begin
                    ent_next.rptr = ent_reg.rptr + PW'(1);
                end
                state_next = S_RDATA;
            end
            S_RDATA:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    res.result_kind   = tsct_pkg::KIND_READ;
                    res.out_socket_id = 3'(idx_reg);
                    res.conn_state    = ent_reg.st;
                    res.read_byte     = buf_rdata;
                    res.last          = (cnt_reg == 7'd1);
                    cnt_next      = cnt_reg - 7'd1;
                    ent_next.fill = ent_reg.fill - FW'(1);
                    if (cnt_reg == 7'd1)
                    begin
                        tab_we     = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_RADDR;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        tab_wdata = (state_reg == S_RDATA) ? ent_next : ent;
        if (load)
        begin
            ov_next  = 1'b1;
            out_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            in_reg    <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            used_reg  <= '0;
            for (int i = 0; i < NUM_CONNECTIONS; i++)
            begin
                port_reg[i] <= '0;
            end
            pe_reg    <= '0;
            pl_reg    <= '0;
            pk_reg    <= 1'b0;
            ent_reg   <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            out_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            in_reg    <= in_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            used_reg  <= used_next;
            port_reg  <= port_next;
            pe_reg    <= pe_next;
            pl_reg    <= pl_next;
            pk_reg    <= pk_next;
            ent_reg   <= ent_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            out_reg   <= out_next;
        end
    end
endmodule

[hdl/tsct_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module tsct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[hdl/tsct_match.sv]
// Connection lookup: last used entry with a given server port, first free entry.
// Depends on nothing.
module tsct_match #(
    parameter int NUM_CONNECTIONS = 8,
    localparam int IW = (NUM_CONNECTIONS > 1) ? $clog2(NUM_CONNECTIONS) : 1
) (
    input  logic [NUM_CONNECTIONS-1:0] used,
    input  logic [15:0]                ports [NUM_CONNECTIONS],
    input  logic [15:0]                key_port,
    output logic                       match_found,
    output logic [IW-1:0]              match_idx,
    output logic                       free_found,
    output logic [IW-1:0]              free_idx
);
    always_comb
    begin
        match_found = 1'b0;
        match_idx   = '0;
        free_found  = 1'b0;
        free_idx    = '0;
        for (int i = 0; i < NUM_CONNECTIONS; i++)
        begin
            if (used[i] && ports[i] == key_port)
            begin
                match_found = 1'b1;
                match_idx   = IW'(i);
            end
        end
        for (int i = NUM_CONNECTIONS - 1; i >= 0; i--)
        begin
            if (!used[i])
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end
endmodule

[hdl/tsct_checker.sv]
// Port-level checker for the connection table, bound to the top level.
// Depends on tsct_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tsct_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input tsct_pkg::out_word_t out_data
);
    logic out_stall;
    logic is_read;
    logic is_status;
    logic stat_ok;

    assign out_stall = out_valid && !out_ready;
    assign is_read   = (out_data.result_kind == tsct_pkg::KIND_READ);
    assign is_status = (out_data.result_kind == tsct_pkg::KIND_STATUS);
    assign stat_ok   = (out_data.status == tsct_pkg::STAT_OK);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_data))
    `ASSERT_ALWAYS(a_last_single, clk, rst_n, !out_valid || is_read || out_data.last)
    `ASSERT_ALWAYS(a_status_kind, clk, rst_n, !out_valid || stat_ok || is_status)
    `ASSERT_ALWAYS(a_burst_busy, clk, rst_n, !(out_valid && is_read && !out_data.last) || !in_ready)
endmodule

bind transport_server_connection_table_top tsct_checker u_tsct_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (rsp.data)
);

[tb/sv/tsct_checker.sv]
// Checker for the transport server connection table: watches both channels,
// predicts the result words of every accepted input word and compares them.
// Depends on tsct_pkg and the channel interfaces in tsct_if.
module tsct_scoreboard (
    input  logic clk,
    input  logic rst_n,
    tsct_in_if   req,
    tsct_out_if  rsp,
    output int   errors,
    output int   outstanding,
    output int   words_out,
    output int   bytes_read,
    output int   replies_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCONN    = 8;
    localparam int BUF      = 1024;
    localparam int MAXPAY   = 1024;
    localparam int MAXRD    = 64;

    logic        used [NCONN];
    logic [1:0]  conn_st [NCONN];
    logic [15:0] srv_port [NCONN];
    logic [15:0] peer_port [NCONN];
    logic [31:0] next_seq [NCONN];
    int          fill [NCONN];
    int          rd_ptr [NCONN];
    logic [7:0]  rx_store [NCONN*BUF];
    int          pay_entry;
    int          pay_left;
    bit          pay_keep;

    tsct_pkg::out_word_t expected_words[$];

    function automatic void push_word(logic [1:0] kind, logic [1:0] stat, logic [2:0] id,
                                      logic [1:0] cst, logic [2:0] rtype, logic [15:0] rsrc,
                                      logic [15:0] rdst, logic [31:0] ack, logic [7:0] data,
                                      logic fin);
        tsct_pkg::out_word_t r;
        r.result_kind     = kind;
        r.status          = stat;
        r.out_socket_id   = id;
        r.conn_state      = cst;
        r.reply_type      = rtype;
        r.reply_src_port  = rsrc;
        r.reply_dest_port = rdst;
        r.reply_ack       = ack;
        r.read_byte       = data;
        r.last            = fin;
        expected_words.push_back(r);
    endfunction

    function automatic void push_none();
        push_word(tsct_pkg::KIND_NONE, tsct_pkg::STAT_OK, 0, tsct_pkg::ST_CLOSED, 0, 0, 0, 0,
                  0, 1'b1);
    endfunction

    function automatic void push_status(logic [1:0] stat, int id, logic [1:0] cst);
        push_word(tsct_pkg::KIND_STATUS, stat, 3'(id), cst, 0, 0, 0, 0, 0, 1'b1);
    endfunction

    function automatic void apply_segment(tsct_pkg::in_word_t w);
        int          e;
        bit          found;
        bit          reply;
        logic [2:0]  rtype;
        logic [31:0] ack;
        e = 0;
        found = 0;
        reply = 0;
        rtype = tsct_pkg::SEG_SYN;
        ack = '0;
        for (int i = 0; i < NCONN; i++)
        begin
            if (used[i] && srv_port[i] == w.seg_dest_port)
            begin
                e = i;
                found = 1;
            end
        end
        pay_left = w.seg_length;
        pay_keep = 0;
        pay_entry = e;
        if (!found)
        begin
            push_none();
            return;
        end
        case (conn_st[e])
            tsct_pkg::ST_LISTEN:
            begin
                if (w.seg_type == tsct_pkg::SEG_SYN)
                begin
                    conn_st[e] = tsct_pkg::ST_CONN;
                    peer_port[e] = w.seg_src_port;
                    next_seq[e] = w.seg_seq;
                    rtype = tsct_pkg::SEG_SYNACK;
                    reply = 1;
                end
            end
            tsct_pkg::ST_CONN:
            begin
                if (w.seg_type == tsct_pkg::SEG_FIN)
                begin
                    conn_st[e] = tsct_pkg::ST_CWAIT;
                    rtype = tsct_pkg::SEG_FINACK;
                    reply = 1;
                end
                else if (w.seg_type == tsct_pkg::SEG_SYN)
                begin
                    rtype = tsct_pkg::SEG_SYNACK;
                    reply = 1;
                end
                else if (w.seg_type == tsct_pkg::SEG_DATA)
                begin
                    if (next_seq[e] == w.seg_seq)
                    begin
                        if (w.seg_length <= MAXPAY && fill[e] + w.seg_length <= BUF)
                        begin
                            pay_keep = 1;
                            next_seq[e] = w.seg_seq + 32'(w.seg_length);
                            rtype = tsct_pkg::SEG_DATAACK;
                            ack = next_seq[e];
                            reply = 1;
                        end
                    end
                    else
                    begin
                        rtype = tsct_pkg::SEG_DATAACK;
                        ack = next_seq[e];
                        reply = 1;
                    end
                end
            end
            tsct_pkg::ST_CWAIT:
            begin
                if (w.seg_type == tsct_pkg::SEG_FIN)
                begin
                    rtype = tsct_pkg::SEG_FINACK;
                    reply = 1;
                end
            end
            default:
            begin
            end
        endcase
        if (!reply)
            push_none();
        else
            push_word(tsct_pkg::KIND_REPLY, tsct_pkg::STAT_OK, 3'(e), conn_st[e], rtype,
                      w.seg_dest_port, w.seg_src_port, ack, 0, 1'b1);
    endfunction

    function automatic void apply_word(tsct_pkg::in_word_t w);
        int  id;
        int  len;
        bit  done;
        id = w.socket_id;
        if (w.is_payload)
        begin
            if (pay_left != 0)
            begin
                pay_left--;
                if (pay_keep && fill[pay_entry] < BUF)
                begin
                    rx_store[pay_entry*BUF + (rd_ptr[pay_entry] + fill[pay_entry]) % BUF] =
                        w.payload_byte;
                    fill[pay_entry]++;
                end
            end
            push_none();
            return;
        end
        case (w.command)
            tsct_pkg::CMD_OPEN:
            begin
                done = 0;
                for (int i = 0; i < NCONN; i++)
                begin
                    if (!done && !used[i])
                    begin
                        used[i] = 1;
                        conn_st[i] = tsct_pkg::ST_CLOSED;
                        srv_port[i] = w.local_port;
                        peer_port[i] = '0;
                        next_seq[i] = '0;
                        fill[i] = 0;
                        rd_ptr[i] = 0;
                        push_status(tsct_pkg::STAT_OK, i, tsct_pkg::ST_CLOSED);
                        done = 1;
                    end
                end
                if (!done)
                    push_status(tsct_pkg::STAT_FULL, 0, tsct_pkg::ST_CLOSED);
            end
            tsct_pkg::CMD_LISTEN:
            begin
                if (!used[id])
                    push_status(tsct_pkg::STAT_BAD, id, tsct_pkg::ST_CLOSED);
                else
                begin
                    conn_st[id] = tsct_pkg::ST_LISTEN;
                    push_status(tsct_pkg::STAT_OK, id, tsct_pkg::ST_LISTEN);
                end
            end
            tsct_pkg::CMD_READ:
            begin
                len = (w.read_length > MAXRD) ? MAXRD : w.read_length;
                if (!used[id])
                    push_status(tsct_pkg::STAT_BAD, id, tsct_pkg::ST_CLOSED);
                else if (fill[id] < len)
                    push_status(tsct_pkg::STAT_SHORT, id, conn_st[id]);
                else if (len == 0)
                    push_status(tsct_pkg::STAT_OK, id, conn_st[id]);
                else
                begin
                    for (int k = 0; k < len; k++)
                    begin
                        push_word(tsct_pkg::KIND_READ, tsct_pkg::STAT_OK, 3'(id), conn_st[id],
                                  0, 0, 0, 0, rx_store[id*BUF + rd_ptr[id]], 1'(k + 1 == len));
                        rd_ptr[id] = (rd_ptr[id] + 1) % BUF;
                    end
                    fill[id] -= len;
                end
            end
            tsct_pkg::CMD_CLOSE:
            begin
                if (!used[id])
                    push_status(tsct_pkg::STAT_BAD, id, tsct_pkg::ST_CLOSED);
                else
                begin
                    used[id] = 0;
                    conn_st[id] = tsct_pkg::ST_CLOSED;
                    fill[id] = 0;
                    rd_ptr[id] = 0;
                    if (pay_entry == id)
                        pay_keep = 0;
                    push_status(tsct_pkg::STAT_OK, id, tsct_pkg::ST_CLOSED);
                end
            end
            tsct_pkg::CMD_SEG:
                apply_segment(w);
            default:
                push_none();
        endcase
    endfunction

    function automatic void check_word(tsct_pkg::out_word_t got);
        tsct_pkg::out_word_t want;
        if (expected_words.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("%0t: result word with nothing expected: %h", $realtime, got);
            return;
        end
        want = expected_words.pop_front();
        if (got !== want)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("%0t: mismatch kind %0d/%0d status %0d/%0d id %0d/%0d state %0d/%0d",
                         $realtime, want.result_kind, got.result_kind, want.status, got.status,
                         want.out_socket_id, got.out_socket_id, want.conn_state,
                         got.conn_state);
                $display("    type %0d/%0d src %h/%h dst %h/%h ack %h/%h data %h/%h last %b/%b",
                         want.reply_type, got.reply_type, want.reply_src_port,
                         got.reply_src_port, want.reply_dest_port, got.reply_dest_port,
                         want.reply_ack, got.reply_ack, want.read_byte, got.read_byte,
                         want.last, got.last);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCONN; i++)
            begin
                used[i] = 0;
                conn_st[i] = tsct_pkg::ST_CLOSED;
                srv_port[i] = '0;
                peer_port[i] = '0;
                next_seq[i] = '0;
                fill[i] = 0;
                rd_ptr[i] = 0;
            end
            pay_entry = 0;
            pay_left = 0;
            pay_keep = 0;
            expected_words.delete();
            errors = 0;
            outstanding = 0;
            words_out = 0;
            bytes_read = 0;
            replies_seen = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                apply_word(req.data);
            if (rsp.valid && rsp.ready)
            begin
                words_out++;
                if (rsp.data.result_kind == tsct_pkg::KIND_READ)
                    bytes_read++;
                if (rsp.data.result_kind == tsct_pkg::KIND_REPLY)
                    replies_seen++;
                check_word(rsp.data);
            end
            outstanding = expected_words.size();
        end
    end

endmodule

[tb/sv/tb_top.sv]
// Top of the connection table testbench: clock, reset, word stimulus with
// random gaps, a stalling receiver and the verdict.
// Depends on tsct_pkg, tsct_if, tsct_scoreboard and the block's top level.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCONN      = 8;
    localparam int BUF        = 1024;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 100;
    localparam int NUM_WORDS  = 180;
    localparam int IN_W       = $bits(tsct_pkg::in_word_t);

    logic clk;
    logic rst_n;
    int   errors;
    int   outstanding;
    int   words_out;
    int   bytes_read;
    int   replies_seen;
    int   words_sent;
    int   idle_cycles;
    bit   no_idle;
    bit   hold_now;

    // Shadow of the table, used only to steer the stimulus toward deep states.
    bit          m_used [NCONN];
    logic [1:0]  m_state [NCONN];
    logic [15:0] m_port [NCONN];
    logic [31:0] m_seq [NCONN];
    int          m_fill [NCONN];
    int          m_pay_entry;
    int          m_pay_left;
    bit          m_pay_keep;
    logic [15:0] port_pool [3] = '{16'h1234, 16'h8000, 16'h00FF};

    tsct_in_if  req_ch ();
    tsct_out_if rsp_ch ();

    transport_server_connection_table_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    tsct_scoreboard u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .errors       (errors),
        .outstanding  (outstanding),
        .words_out    (words_out),
        .bytes_read   (bytes_read),
        .replies_seen (replies_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_now)
            begin
                rsp_ch.ready = 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
                hold_now = 0;
            end
            n = no_idle ? 0 : $urandom_range(0, 4);
            if (n > 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat (n) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
        end
    end

    function automatic tsct_pkg::in_word_t rand_word();
        tsct_pkg::in_word_t w;
        logic [127:0]       raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        w = raw[IN_W-1:0];
        w.is_payload = 1'b0;
        return w;
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            5: return 16'($urandom);
            default: return port_pool[$urandom_range(0, 2)];
        endcase
    endfunction

    function automatic int pick_id();
        int id;
        id = $urandom_range(0, NCONN - 1);
        if ($urandom_range(0, 9) < 8)
            for (int k = 0; k < NCONN; k++)
                if (m_used[(id + k) % NCONN])
                    return (id + k) % NCONN;
        return id;
    endfunction

    task automatic send_word(tsct_pkg::in_word_t w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.data = w;
        req_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic send_open(logic [15:0] port);
        tsct_pkg::in_word_t w;
        bit                 done;
        w = rand_word();
        w.command = tsct_pkg::CMD_OPEN;
        w.local_port = port;
        send_word(w);
        done = 0;
        for (int i = 0; i < NCONN; i++)
            if (!done && !m_used[i])
            begin
                m_used[i] = 1;
                m_state[i] = tsct_pkg::ST_CLOSED;
                m_port[i] = port;
                m_seq[i] = '0;
                m_fill[i] = 0;
                done = 1;
            end
    endtask

    task automatic send_listen(int id);
        tsct_pkg::in_word_t w;
        w = rand_word();
        w.command = tsct_pkg::CMD_LISTEN;
        w.socket_id = 3'(id);
        send_word(w);
        if (m_used[id])
            m_state[id] = tsct_pkg::ST_LISTEN;
    endtask

    task automatic send_read(int id, int len);
        tsct_pkg::in_word_t w;
        int                 eff;
        w = rand_word();
        w.command = tsct_pkg::CMD_READ;
        w.socket_id = 3'(id);
        w.read_length = 7'(len);
        send_word(w);
        eff = (len > 64) ? 64 : len;
        if (m_used[id] && m_fill[id] >= eff)
            m_fill[id] -= eff;
    endtask

    task automatic send_close(int id);
        tsct_pkg::in_word_t w;
        w = rand_word();
        w.command = tsct_pkg::CMD_CLOSE;
        w.socket_id = 3'(id);
        send_word(w);
        if (m_used[id])
        begin
            m_used[id] = 0;
            m_state[id] = tsct_pkg::ST_CLOSED;
            m_fill[id] = 0;
            if (m_pay_entry == id)
                m_pay_keep = 0;
        end
    endtask

    task automatic send_payload();
        tsct_pkg::in_word_t w;
        w = rand_word();
        w.is_payload = 1'b1;
        send_word(w);
        if (m_pay_left > 0)
        begin
            m_pay_left--;
            if (m_pay_keep && m_fill[m_pay_entry] < BUF)
                m_fill[m_pay_entry]++;
        end
    endtask

    // Sends a header and npay payload words; with mix set, commands may land
    // between the payload words.
    task automatic send_segment(logic [2:0] stype, logic [15:0] dst, logic [31:0] seq,
                                int len, int npay, bit mix);
        tsct_pkg::in_word_t w;
        int                 e;
        bit                 found;
        w = rand_word();
        w.command = tsct_pkg::CMD_SEG;
        w.seg_type = stype;
        w.seg_dest_port = dst;
        w.seg_seq = seq;
        w.seg_length = 11'(len);
        send_word(w);
        e = 0;
        found = 0;
        for (int i = 0; i < NCONN; i++)
            if (m_used[i] && m_port[i] == dst)
            begin
                e = i;
                found = 1;
            end
        m_pay_left = len;
        m_pay_keep = 0;
        m_pay_entry = e;
        if (found)
        begin
            if (m_state[e] == tsct_pkg::ST_LISTEN && stype == tsct_pkg::SEG_SYN)
            begin
                m_state[e] = tsct_pkg::ST_CONN;
                m_seq[e] = seq;
            end
            else if (m_state[e] == tsct_pkg::ST_CONN && stype == tsct_pkg::SEG_FIN)
                m_state[e] = tsct_pkg::ST_CWAIT;
            else if (m_state[e] == tsct_pkg::ST_CONN && stype == tsct_pkg::SEG_DATA &&
                     m_seq[e] == seq && len <= 1024 && m_fill[e] + len <= BUF)
            begin
                m_pay_keep = 1;
                m_seq[e] = seq + 32'(len);
            end
        end
        for (int k = 0; k < npay; k++)
        begin
            if (mix && $urandom_range(0, 19) == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_close(pick_id());
                else
                    send_read(pick_id(), $urandom_range(0, 8));
            end
            send_payload();
        end
    endtask

    task automatic establish();
        int id;
        logic [15:0] port;
        id = -1;
        for (int i = NCONN - 1; i >= 0; i--)
            if (!m_used[i])
                id = i;
        if (id < 0)
        begin
            id = $urandom_range(0, NCONN - 1);
            send_close(id);
        end
        port = pick_port();
        send_open(port);
        send_listen(id);
        send_segment(tsct_pkg::SEG_SYN, port, $urandom, 0, 0, 0);
    endtask

    function automatic int conn_id();
        int id;
        id = $urandom_range(0, NCONN - 1);
        for (int k = 0; k < NCONN; k++)
            if (m_used[(id + k) % NCONN] && m_state[(id + k) % NCONN] == tsct_pkg::ST_CONN)
                return (id + k) % NCONN;
        return -1;
    endfunction

    initial
    begin
        tsct_pkg::in_word_t w;
        int          id;
        int          len;
        int          r;
        int          n;
        logic [31:0] seq;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rst_n = 1'b0;
        no_idle = 0;
        hold_now = 0;
        words_sent = 0;
        idle_cycles = 0;
        m_pay_entry = 0;
        m_pay_left = 0;
        m_pay_keep = 0;
        for (int i = 0; i < NCONN; i++)
        begin
            m_used[i] = 0;
            m_state[i] = tsct_pkg::ST_CLOSED;
            m_port[i] = '0;
            m_seq[i] = '0;
            m_fill[i] = 0;
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: duplicate ports, sequence wrap, no room, bad entries.
        send_payload();
        send_open(16'hABCD);
        send_open(16'hABCD);
        send_listen(1);
        send_segment(tsct_pkg::SEG_SYN, 16'hABCD, 32'hFFFF_FFF0, 0, 0, 0);
        send_segment(tsct_pkg::SEG_DATA, 16'hABCD, 32'hFFFF_FFF0, 20, 20, 0);
        send_segment(tsct_pkg::SEG_DATA, 16'hABCD, 32'h1234_5678, 3, 3, 0);
        send_read(1, 0);
        send_read(1, 10);
        send_read(1, 127);
        send_segment(tsct_pkg::SEG_DATA, 16'hABCD, m_seq[1], 1014, 6, 0);
        send_segment(tsct_pkg::SEG_DATA, 16'hABCD, m_seq[1], 1, 1, 0);
        send_segment(tsct_pkg::SEG_DATA, 16'hABCD, m_seq[1], 1010, 2, 0);
        send_segment(tsct_pkg::SEG_DATA, 16'hABCD, m_seq[1], 2047, 3, 0);
        send_read(1, 127);
        send_segment(tsct_pkg::SEG_SYN, 16'hABCD, 32'h0, 0, 0, 0);
        send_segment(tsct_pkg::SEG_FIN, 16'hABCD, 32'h0, 0, 0, 0);
        send_segment(tsct_pkg::SEG_FIN, 16'hABCD, 32'h0, 0, 0, 0);
        send_segment(tsct_pkg::SEG_SYN, 16'hABCD, 32'h0, 0, 0, 0);
        send_segment(tsct_pkg::SEG_SYN, 16'h0000, 32'h0, 4, 4, 0);
        send_listen(5);
        send_read(7, 1);
        send_close(6);
        for (int c = 5; c <= 7; c++)
        begin
            w = rand_word();
            w.command = 3'(c);
            send_word(w);
        end
        for (int i = 0; i < 7; i++)
            send_open(16'hFFFF);
        send_listen(0);
        send_segment(tsct_pkg::SEG_SYN, 16'hABCD, 32'h0, 0, 0, 0);
        send_segment(tsct_pkg::SEG_DATA, 16'hABCD, 32'h0, 4, 2, 0);
        send_close(1);
        send_payload();
        send_payload();
        for (int i = 0; i < NCONN; i++)
            send_close(i);

        // Random: mostly well-formed sessions with random content.
        n = 0;
        while (words_sent < NUM_WORDS)
        begin
            no_idle = ((n / 10) % 3 == 1);
            if (n == 5)
                hold_now = 1;
            if (conn_id() < 0)
                establish();
            r = $urandom_range(0, 99);
            if (r < 8)
                send_open(pick_port());
            else if (r < 14)
                send_listen(pick_id());
            else if (r < 24)
            begin
                id = pick_id();
                len = $urandom_range(0, 2);
                send_segment(tsct_pkg::SEG_SYN, m_used[id] ? m_port[id] : pick_port(),
                             $urandom, len, len, 1);
            end
            else if (r < 58)
            begin
                id = conn_id();
                if (id < 0)
                    id = pick_id();
                seq = ($urandom_range(0, 4) != 0) ? m_seq[id] : $urandom;
                if ($urandom_range(0, 29) == 0)
                    len = $urandom_range(1025, 2047);
                else if ($urandom_range(0, 19) == 0)
                    len = $urandom_range(13, 40);
                else
                    len = $urandom_range(0, 12);
                send_segment(tsct_pkg::SEG_DATA, m_port[id], seq, len,
                             ($urandom_range(0, 9) == 0 || len > 1024) ?
                             $urandom_range(0, (len > 12) ? 12 : len) : len, 1);
            end
            else if (r < 78)
                send_read(pick_id(), ($urandom_range(0, 9) == 0) ?
                          $urandom_range(65, 127) : $urandom_range(0, 24));
            else if (r < 83)
            begin
                id = pick_id();
                send_segment(tsct_pkg::SEG_FIN, m_port[id], $urandom, 0, 0, 1);
            end
            else if (r < 87)
                send_close(pick_id());
            else if (r < 92)
            begin
                id = pick_id();
                case ($urandom_range(0, 2))
                    0: send_segment(tsct_pkg::SEG_SYNACK, m_port[id], $urandom, 1, 1, 1);
                    1: send_segment(tsct_pkg::SEG_FINACK, pick_port(), $urandom, 0, 0, 1);
                    default: send_segment(tsct_pkg::SEG_DATAACK, m_port[id], $urandom, 2, 2,
                                          1);
                endcase
            end
            else if (r < 96)
            begin
                w = rand_word();
                w.command = 3'($urandom_range(5, 7));
                send_word(w);
            end
            else
                send_payload();
            n++;
        end

        req_ch.valid = 1'b0;
        no_idle = 0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Sent %0d input words; checked %0d result words, %0d read bytes, %0d replies.",
                 words_sent, words_out, bytes_read, replies_seen);
        if (errors == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[transport_server_connection_table_top.f]
+incdir+hdl
hdl/tsct_pkg.sv
hdl/tsct_if.sv
hdl/tsct_ram.sv
hdl/tsct_match.sv
hdl/transport_server_connection_table_top.sv
hdl/tsct_checker.sv
tb/sv/tsct_checker.sv
tb/sv/tb_top.sv
